>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the stencil pass unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while the active-low reset is asserted.
`define HDS_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is checked on every edge, reset included.
`define HDS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/hds_pkg.sv
// Shared types and constants of the heat diffusion stencil pass unit.
package hds_pkg;

    // Field and bus widths.
    localparam int CELL_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int CFG_LEN_W  = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_IDX_W  = 10;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - CELL_W - 2 * OUT_IDX_W;

    // Arithmetic widths: the stencil sum needs 35 bits, the product 52.
    localparam int SUM_W   = 35;
    localparam int PROD_W  = 52;
    localparam int FRAC_W  = 16;
    localparam int DELTA_W = PROD_W - FRAC_W;
    localparam int FULL_W  = DELTA_W + 1;
    localparam int ROUND_BIAS = 32768;

    // Geometry and register reset values.
    localparam int GRID_MIN  = 3;
    localparam int RESET_LEN = 1024;
    localparam logic [GAIN_W-1:0] RESET_GAIN = 16'd16384;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_GAIN = 2'd2;

    // Stencil window cells and result queue.
    localparam int WINDOW_CELLS = 2;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = 3;
    localparam int FIFO_CW      = 4;

    // One grid column of the two stored rows: row r-2 above row r-1.
    typedef struct packed {
        logic signed [CELL_W-1:0] upper;
        logic signed [CELL_W-1:0] middle;
    } col_pair_t;

    // Control that travels with an item through the update pipeline.
    typedef struct packed {
        logic                 has_a;
        logic                 has_b;
        logic                 border;
        logic                 last;
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
    } item_ctl_t;

    // One queue entry: the updated cell of row r-1 and, if flagged,
    // the zero border cell of row r in the same column.
    typedef struct packed {
        logic signed [CELL_W-1:0] value;
        logic [OUT_IDX_W-1:0]     row;
        logic [OUT_IDX_W-1:0]     col;
        logic                     has_a;
        logic                     has_b;
        logic                     last;
    } result_t;

endpackage

>>> sv/heat_diffusion_stencil_pass_unit.sv
// Top level of the streaming five-point heat diffusion stencil pass.
//
// Grid cells enter on the s_ stream in raster order, one signed Q16.16 word
// per handshake, and updated cells leave on the m_ stream with their row and
// column. When cell (r,c) is taken, the result word for (r-1,c) is produced;
// cells on the grid border come out as zero. Words of the last row also
// produce their own zero border word right after, and the final one of the
// frame carries m_tlast. Row 0 words produce nothing on their own.
// Geometry and gain are set through the cfg_wr_ port while the unit is idle;
// the user must keep to this, as the unit itself does not enforce it; any write
// to a known register restarts the frame at row 0, column 0. Each result word is
// registered in the arithmetic pipeline and the queue before it reaches m_.
// Throughput is one input word per cycle while s_tready is high, set by the
// line buffer memory, which takes one read and one write per cycle, and the
// shift of the window cells; the last row gives two result words per input word.
// Results wait in an eight-entry queue; s_tready falls once the queue and the
// arithmetic pipeline together hold eight entries, so a stalled receiver
// stops the input side without losing words. Reset returns the counters and
// registers to their defaults; the row memory is not cleared and no clearing
// pass runs; s_tready is low during reset and in the cycle after it.
module heat_diffusion_stencil_pass_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata fields from bit 0 up: cell_value[31:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hds_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata fields from bit 0 up: new_value[31:0], out_row[41:32],
    // out_col[51:42], zero fill[55:52]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hds_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [hds_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [hds_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import hds_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [CW-1:0] LAST_COL_RST =
        CW'(((RESET_LEN > MAX_WIDTH) ? MAX_WIDTH : RESET_LEN) - 1);
    localparam logic [RW-1:0] LAST_ROW_RST =
        RW'(((RESET_LEN > MAX_HEIGHT) ? MAX_HEIGHT : RESET_LEN) - 1);

    // Out-of-range lengths act as the nearest legal one; the registers keep
    // the index of the last column and the last row.
    function automatic logic [CW-1:0] clamp_col(input logic [CFG_LEN_W-1:0] v);
        logic [CW-1:0] r;
        if (v < CFG_LEN_W'(GRID_MIN)) begin
            r = CW'(GRID_MIN - 1);
        end else if (32'(v) > MAX_WIDTH) begin
            r = CW'(MAX_WIDTH - 1);
        end else begin
            r = CW'(v - 1'b1);
        end
        return r;
    endfunction

    function automatic logic [RW-1:0] clamp_row(input logic [CFG_LEN_W-1:0] v);
        logic [RW-1:0] r;
        if (v < CFG_LEN_W'(GRID_MIN)) begin
            r = RW'(GRID_MIN - 1);
        end else if (32'(v) > MAX_HEIGHT) begin
            r = RW'(MAX_HEIGHT - 1);
        end else begin
            r = RW'(v - 1'b1);
        end
        return r;
    endfunction

    // Configuration registers and position counters.
    logic [CW-1:0]     last_col_reg, last_col_next;
    logic [RW-1:0]     last_row_reg, last_row_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic              ready_en_reg, ready_en_next;
    logic              cfg_hit;

    // Item handling.
    logic              in_acc;
    logic              at_last_col, at_last_row;
    logic              has_a, has_b, border;
    logic [CW-1:0]     prefetch_addr;
    item_ctl_t         item_ctl;

    // Line buffer and window chain.
    col_pair_t         east_pair;
    col_pair_t         wr_pair;
    col_pair_t         chain [WINDOW_CELLS+1];

    // Arithmetic pipeline.
    logic              upd_valid;
    result_t           upd_result;
    logic [1:0]        upd_inflight;

    // Result queue.
    result_t                fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]     count_reg, count_next;
    logic                   sel_b_reg, sel_b_next;
    logic [FIFO_CW:0]       occupancy;
    result_t                head;
    logic                   beat_b;
    logic                   out_acc;
    logic                   push, pop;
    logic signed [CELL_W-1:0] out_value;
    logic [OUT_IDX_W-1:0]   out_row;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Configuration writes; a write to a known index restarts the frame.
    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        gain_next     = gain_reg;
        cfg_hit       = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ROW_LENGTH: begin
                    cfg_hit       = 1'b1;
                    last_col_next = clamp_col(cfg_wr_data[CFG_LEN_W-1:0]);
                end
                CFG_ROW_COUNT: begin
                    cfg_hit       = 1'b1;
                    last_row_next = clamp_row(cfg_wr_data[CFG_LEN_W-1:0]);
                end
                CFG_DIFFUSION_GAIN: begin
                    cfg_hit   = 1'b1;
                    gain_next = cfg_wr_data[GAIN_W-1:0];
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Where the incoming word sits in the grid and what it produces.
    always_comb begin
        at_last_col = col_reg >= last_col_reg;
        at_last_row = row_reg >= last_row_reg;
        has_a       = row_reg != '0;
        has_b       = at_last_row;
        border      = (row_reg == RW'(1)) || ((row_reg - RW'(1)) >= last_row_reg)
                   || (col_reg == '0) || at_last_col;
        item_ctl.has_a  = has_a;
        item_ctl.has_b  = has_b;
        item_ctl.border = border;
        item_ctl.last   = at_last_row && at_last_col;
        item_ctl.row    = OUT_IDX_W'(row_reg);
        item_ctl.col    = OUT_IDX_W'(col_reg);
    end

    // Counters step on every taken word, wrap at the end of the frame and clear on a configuration write.
    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        ready_en_next = 1'b1;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (in_acc) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= LAST_COL_RST;
            last_row_reg <= LAST_ROW_RST;
            gain_reg     <= RESET_GAIN;
            col_reg      <= '0;
            row_reg      <= '0;
            ready_en_reg <= 1'b0;
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            gain_reg     <= gain_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            ready_en_reg <= ready_en_next;
        end
    end

    // The memory is read two columns ahead: while column c is taken, the
    // read for column c+2 starts, wrapping to columns 0 and 1 at row end.
    // Its registered output is then the east column of the next word.
    always_comb begin
        if (col_reg == last_col_reg) begin
            prefetch_addr = CW'(1);
        end else if ((col_reg + CW'(1)) == last_col_reg) begin
            prefetch_addr = '0;
        end else begin
            prefetch_addr = col_reg + CW'(2);
        end
    end

    // The center column moves up a row: its middle becomes the upper entry.
    always_comb begin
        wr_pair.upper  = chain[1].middle;
        wr_pair.middle = $signed(s_tdata[CELL_W-1:0]);
    end

    hds_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (in_acc),
        .rd_addr (prefetch_addr),
        .rd_data (east_pair),
        .wr_en   (in_acc),
        .wr_addr (col_reg),
        .wr_data (wr_pair)
    );

    // Window chain: east column from memory, then center, then west.
    assign chain[0] = east_pair;

    for (genvar i = 0; i < WINDOW_CELLS; i++) begin : g_window
        hds_window_cell u_cell (
            .aclk     (aclk),
            .shift_en (in_acc),
            .pair_in  (chain[i]),
            .pair_out (chain[i+1])
        );
    end

    hds_update u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_acc && (has_a || has_b)),
        .in_ctl     (item_ctl),
        .north      (chain[1].upper),
        .south      ($signed(s_tdata[CELL_W-1:0])),
        .east       (chain[0].middle),
        .west       (chain[WINDOW_CELLS].middle),
        .center     (chain[1].middle),
        .gain       (gain_reg),
        .out_valid  (upd_valid),
        .out_result (upd_result),
        .inflight   (upd_inflight)
    );

    // Input is taken only while the queue has room for everything in flight.
    always_comb begin
        occupancy = {1'b0, count_reg} + (FIFO_CW+1)'(upd_inflight);
        s_tready  = ready_en_reg && (occupancy < (FIFO_CW+1)'(FIFO_DEPTH));
    end

    // Result queue: an entry leaves in one word, or two on the last row.
    always_comb begin
        head    = fifo_mem_reg[rd_ptr_reg];
        beat_b  = sel_b_reg || !head.has_a;
        push    = upd_valid;
        pop     = out_acc && (beat_b || !head.has_b);
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        sel_b_next  = sel_b_reg;
        if (out_acc) begin
            sel_b_next = !pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sel_b_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sel_b_reg  <= sel_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= upd_result;
        end
    end

    // The first word of an entry is row r-1; the second is the zero border
    // word of row r itself.
    always_comb begin
        out_value = beat_b ? '0 : head.value;
        out_row   = beat_b ? head.row : head.row - OUT_IDX_W'(1);
        m_tvalid  = count_reg != '0;
        m_tdata   = {{M_PAD_W{1'b0}}, head.col, out_row, out_value};
        m_tlast   = beat_b && head.last;
    end

endmodule

>>> sv/hds_line_buf.sv
// Line buffer memory holding the two previous grid rows, one column per word.
module hds_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output hds_pkg::col_pair_t rd_data,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  hds_pkg::col_pair_t wr_data
);
    import hds_pkg::*;

    col_pair_t mem [DEPTH];
    col_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/hds_window_cell.sv
// One column cell of the stencil window; it takes its neighbor's column on each shift.
module hds_window_cell (
    input  logic               aclk,
    input  logic               shift_en,
    input  hds_pkg::col_pair_t pair_in,
    output hds_pkg::col_pair_t pair_out
);
    import hds_pkg::*;

    col_pair_t pair_reg;
    col_pair_t pair_next;

    always_comb begin
        pair_next = shift_en ? pair_in : pair_reg;
    end

    always_ff @(posedge aclk) begin
        pair_reg <= pair_next;
    end

    assign pair_out = pair_reg;

endmodule

>>> sv/hds_update.sv
// Three-stage stencil arithmetic: sum, gain multiply, rounding with saturation.
module hds_update (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  hds_pkg::item_ctl_t                  in_ctl,
    input  logic signed [hds_pkg::CELL_W-1:0]   north,
    input  logic signed [hds_pkg::CELL_W-1:0]   south,
    input  logic signed [hds_pkg::CELL_W-1:0]   east,
    input  logic signed [hds_pkg::CELL_W-1:0]   west,
    input  logic signed [hds_pkg::CELL_W-1:0]   center,
    input  logic [hds_pkg::GAIN_W-1:0]          gain,
    output logic                                out_valid,
    output hds_pkg::result_t                    out_result,
    output logic [1:0]                          inflight
);
    import hds_pkg::*;

    logic                     v1_reg, v1_next;
    logic                     v2_reg, v2_next;
    item_ctl_t                ctl1_reg, ctl2_reg;
    logic signed [CELL_W-1:0] c1_reg, c2_reg;
    logic signed [SUM_W-1:0]  sum1_reg, sum1_next;
    logic signed [PROD_W-1:0] prod2_reg, prod2_next;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] rounded;
    logic signed [DELTA_W-1:0] delta;
    logic signed [FULL_W-1:0] total;
    logic [FULL_W-CELL_W:0]   top_bits;
    logic signed [CELL_W-1:0] sat_value;

    // Stage 1: N + S + E + W - 4C, exact at 35 bits.
    always_comb begin
        sum1_next = SUM_W'(north) + SUM_W'(south) + SUM_W'(east) + SUM_W'(west)
                  - (SUM_W'(center) <<< 2);
    end

    // Stage 2: signed sum times the unsigned Q0.16 gain.
    always_comb begin
        gain_s     = $signed({1'b0, gain});
        prod2_next = PROD_W'(sum1_reg) * PROD_W'(gain_s);
    end

    // Stage 3: round to nearest (ties up), add the center cell, saturate.
    always_comb begin
        rounded  = prod2_reg + PROD_W'(ROUND_BIAS);
        delta    = $signed(rounded[PROD_W-1:FRAC_W]);
        total    = FULL_W'(c2_reg) + FULL_W'(delta);
        top_bits = total[FULL_W-1:CELL_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            sat_value = total[CELL_W-1:0];
        end else if (total[FULL_W-1]) begin
            sat_value = {1'b1, {(CELL_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(CELL_W-1){1'b1}}};
        end
    end

    always_comb begin
        v1_next = in_valid;
        v2_next = v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum1_reg  <= sum1_next;
        ctl1_reg  <= in_ctl;
        c1_reg    <= center;
        prod2_reg <= prod2_next;
        ctl2_reg  <= ctl1_reg;
        c2_reg    <= c1_reg;
    end

    always_comb begin
        out_valid        = v2_reg;
        out_result.value = ctl2_reg.border ? '0 : sat_value;
        out_result.row   = ctl2_reg.row;
        out_result.col   = ctl2_reg.col;
        out_result.has_a = ctl2_reg.has_a;
        out_result.has_b = ctl2_reg.has_b;
        out_result.last  = ctl2_reg.last;
        inflight         = {1'b0, v1_reg} + {1'b0, v2_reg};
    end

endmodule

>>> sv/hds_checker.sv
// Port-level checker of the stencil pass unit and its bind to the top level.
`include "assert_macros.svh"

module hds_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hds_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import hds_pkg::*;

    // A word the receiver has not taken stays on the bus unchanged.
    `HDS_ASSERT_RST(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")

    // The closing word of a frame is a border cell and must be zero.
    `HDS_ASSERT_RST(a_last_is_zero, aclk, aresetn, m_tvalid && m_tlast |-> m_tdata[CELL_W-1:0] == '0, "frame end word is not zero")

    // No input word is taken in the cycle after reset is applied.
    `HDS_ASSERT_ALWAYS(a_reset_blocks_input, aclk, !aresetn |=> !s_tready, "input ready right after reset")

endmodule

bind heat_diffusion_stencil_pass_unit hds_checker u_hds_checker (.*);
